>>> design/u8bom_pkg.sv
// Shared types, encoding codes and the byte scan function of the UTF-8/BOM detector.
`default_nettype none
package u8bom_pkg;

    localparam logic [2:0] ENC_ASCII    = 3'd0;
    localparam logic [2:0] ENC_UCS2_LE  = 3'd1;
    localparam logic [2:0] ENC_UCS2_BE  = 3'd2;
    localparam logic [2:0] ENC_UTF8_BOM = 3'd3;
    localparam logic [2:0] ENC_UTF8     = 3'd4;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_BODY   = 2'd3;

    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_FE = 8'hFE;
    localparam logic [7:0] BOM_EF  = 8'hEF;
    localparam logic [7:0] BOM_BB  = 8'hBB;
    localparam logic [7:0] BOM_BF  = 8'hBF;

    typedef struct packed {
        logic [15:0] header;
        logic [1:0]  pos;
        logic [1:0]  pend;
        logic        bom;
        logic        done;
        logic [2:0]  verdict;
    } t_state;

    function automatic logic [2:0] utf8_code(input logic bom);
        return bom ? ENC_UTF8_BOM : ENC_UTF8;
    endfunction

    // Validate one byte against the pending multibyte sequence, or check it as a lead byte when none is pending.
    function automatic t_state scan_byte(input t_state s, input logic [7:0] b);
        t_state r;
        r = s;
        if (!s.done) begin
            if (s.pend != 2'd0) begin
                if (b == 8'h00) begin
                    r.verdict = utf8_code(s.bom);
                    r.done    = 1'b1;
                end else if (b[7:6] != 2'b10) begin
                    r.verdict = ENC_ASCII;
                    r.done    = 1'b1;
                end else begin
                    r.pend = s.pend - 2'd1;
                end
            end else if (b inside {8'hC0, 8'hC1, [8'hF5:8'hFF]}) begin
                r.verdict = ENC_ASCII;
                r.done    = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                r.pend = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                r.pend = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                r.pend = 2'd3;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/u8bom_step.sv
// Next-state and verdict logic for one accepted stream byte.
`default_nettype none
module u8bom_step (
    input  wire u8bom_pkg::t_state i_state,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_byte,
    output u8bom_pkg::t_state      o_state,
    output logic [2:0]             o_encoding
);

    u8bom_pkg::t_state s;
    logic [7:0] b0;
    logic [7:0] b1;

    assign b0 = i_state.header[7:0];
    assign b1 = i_state.header[15:8];

    always_comb begin
        s          = i_state;
        o_encoding = u8bom_pkg::ENC_ASCII;
        if (!i_state.done) begin
            case (i_state.pos)
                u8bom_pkg::POS_FIRST: begin
                    s.header = {8'h00, i_data_byte};
                    if (i_last_byte) begin
                        s.verdict = u8bom_pkg::ENC_ASCII;
                        s.done    = 1'b1;
                    end
                end
                u8bom_pkg::POS_SECOND: begin
                    s.header = {i_data_byte, b0};
                    if (b0 == u8bom_pkg::BYTE_FF && i_data_byte == u8bom_pkg::BYTE_FE) begin
                        s.verdict = u8bom_pkg::ENC_UCS2_LE;
                        s.done    = 1'b1;
                    end else if (b0 == u8bom_pkg::BYTE_FE &&
                                 i_data_byte == u8bom_pkg::BYTE_FF) begin
                        s.verdict = u8bom_pkg::ENC_UCS2_BE;
                        s.done    = 1'b1;
                    end else if (i_last_byte) begin
                        s = u8bom_pkg::scan_byte(s, b0);
                        s = u8bom_pkg::scan_byte(s, i_data_byte);
                    end
                end
                u8bom_pkg::POS_THIRD: begin
                    // Accept the BOM in either byte order of its first two bytes.
                    if (i_data_byte == u8bom_pkg::BOM_BF &&
                        ((b0 == u8bom_pkg::BOM_EF && b1 == u8bom_pkg::BOM_BB) ||
                         (b0 == u8bom_pkg::BOM_BB && b1 == u8bom_pkg::BOM_EF))) begin
                        s.bom = 1'b1;
                    end else begin
                        s = u8bom_pkg::scan_byte(s, b0);
                        s = u8bom_pkg::scan_byte(s, b1);
                        s = u8bom_pkg::scan_byte(s, i_data_byte);
                    end
                end
                default: begin
                    s = u8bom_pkg::scan_byte(s, i_data_byte);
                end
            endcase
        end
        if (i_state.pos != u8bom_pkg::POS_BODY) begin
            s.pos = i_state.pos + 2'd1;
        end
        if (i_last_byte) begin
            o_encoding = s.done ? s.verdict : u8bom_pkg::utf8_code(s.bom);
            s          = '0;
        end
    end

    assign o_state = s;

endmodule
`default_nettype wire

>>> design/utf8_bom_encoding_detector_top.sv
// Top level of the UTF-8 / BOM / UCS-2 encoding detector.
//
// Input channel: i_valid / o_ready carry one stream byte per word
// (i_data_byte) with i_last_byte marking the final byte of a stream.
// Output channel: o_valid / i_ready carry one verdict (o_encoding) per
// stream: 0 ascii, 1 ucs2 little endian, 2 ucs2 big endian,
// 3 utf8 with bom, 4 utf8 without bom.
// Throughput: one byte per cycle unless stalled; the scan state
// updates in the cycle a word is accepted, through the step logic into
// the state register. Latency: the verdict is valid in the cycle after
// the last byte is accepted, held in the output register.
// Stall: while the verdict waits and i_ready is low, o_ready drops; bytes
// keep flowing whenever the output register is empty or being drained.
// Reset (synchronous, active low): scan state clears and no verdict is
// pending. The scan state also returns to reset after each last byte.
`default_nettype none
module utf8_bom_encoding_detector_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_encoding
);

    u8bom_pkg::t_state r_state;
    u8bom_pkg::t_state n_state;
    logic [2:0]        n_enc;
    logic [2:0]        r_enc;
    logic              r_out_valid;
    logic              accept;

    u8bom_step u_step (
        .i_state     (r_state),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_state     (n_state),
        .o_encoding  (n_enc)
    );

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept && i_last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the verdict word only at a last byte.
    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_enc <= n_enc;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_encoding = r_enc;

`ifndef ASSERT_OFF
    a_last_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_byte |=> o_valid)
        else $error("no verdict after last byte");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_encoding <= u8bom_pkg::ENC_UTF8)
        else $error("verdict code out of range");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_byte |=> r_state.pos == u8bom_pkg::POS_FIRST && !r_state.done
            && r_state.pend == 2'd0 && !r_state.bom)
        else $error("scan state not cleared after last byte");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a waiting verdict");
`endif

endmodule
`default_nettype wire
